// ----- rtl/cpt_pkg.sv -----
// shared constants and region codes for the closest point on triangle block
`timescale 1ns / 1ps
`default_nettype none
package cpt_pkg;

  localparam int unsigned CoordBitsDef = 16;

  typedef enum logic [2:0] {
    RegVtxA   = 3'd0,
    RegVtxB   = 3'd1,
    RegEdgeAb = 3'd2,
    RegVtxC   = 3'd3,
    RegEdgeAc = 3'd4,
    RegEdgeBc = 3'd5,
    RegFace   = 3'd6
  } region_e;

endpackage
`default_nettype wire

// ----- rtl/closest_point_on_triangle.sv -----
// pipelined closest point on triangle using voronoi region tests
//
// channel   direction  handshake          payload
// request   in         start_i / busy_o   px_i py_i pz_i ax_i ay_i az_i bx_i by_coord_i bz_i
//                                          cx_i cy_i cz_i
// result    out        done_o strobe      qx_o qy_o qz_o region_o degenerate_o
//
// one request accepted per cycle, busy_o is always low
// the rounding divider resolves one quotient bit per stage (COORD_BITS + 4 stages)
// reset clears only the valid bits that travel with the data
// results come out as a one-cycle strobe and cannot be held off
`timescale 1ns / 1ps
`default_nettype none
module closest_point_on_triangle #(
  parameter int unsigned COORD_BITS = cpt_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  input  logic signed [COORD_BITS-1:0] pz_i,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] az_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_coord_i,
  input  logic signed [COORD_BITS-1:0] bz_i,
  input  logic signed [COORD_BITS-1:0] cx_i,
  input  logic signed [COORD_BITS-1:0] cy_i,
  input  logic signed [COORD_BITS-1:0] cz_i,
  output logic                         done_o,
  output logic signed [COORD_BITS-1:0] qx_o,
  output logic signed [COORD_BITS-1:0] qy_o,
  output logic signed [COORD_BITS-1:0] qz_o,
  output logic [2:0]                   region_o,
  output logic                         degenerate_o
);

  localparam int C   = COORD_BITS;
  localparam int PW2 = 2 * C + 2;
  localparam int DW  = 2 * C + 4;
  localparam int H   = DW / 2;
  localparam int LW  = DW + H + 1;
  localparam int HW  = 2 * DW - H;
  localparam int VW  = 2 * DW + 1;
  localparam int FDW = VW + 2;
  localparam int K   = 2 * C;
  localparam int NCH = (VW + K - 1) / K;
  localparam int FPW = NCH * K;
  localparam int PW  = C + K + 2;
  localparam int NW  = VW + C + 2;
  localparam int D2W = FDW + 1;
  localparam int QB  = C + 4;
  localparam int EW  = D2W + QB;
  localparam int NS  = QB + 10;

  typedef struct packed {
    logic [2:0][C-1:0] a;
    logic [2:0][C-1:0] b;
    logic [2:0][C-1:0] c;
    logic [2:0][C:0]   ab;
    logic [2:0][C:0]   ac;
    logic [2:0][C:0]   bc;
  } geo_t;

  typedef struct packed {
    cpt_pkg::region_e  region;
    logic              vtx;
    logic              deg;
    logic [2:0][C-1:0] fq;
    logic [2:0][C-1:0] base;
    logic signed [FDW-1:0] den;
  } pre_t;

  typedef struct packed {
    cpt_pkg::region_e  region;
    logic              deg;
    logic              fb;
    logic [2:0][C-1:0] fq;
    logic [2:0][C-1:0] base;
    logic [2:0]        neg;
    logic [D2W-1:0]    d2;
  } side_t;

  function automatic logic [C:0] sx1(logic [C-1:0] v);
    return {v[C-1], v};
  endfunction

  function automatic logic le0(logic signed [VW-1:0] v);
    return v[VW-1] | (v == '0);
  endfunction

  logic [NS-1:0] vld_q;
  logic          acc;

  assign busy_o = 1'b0;
  assign acc    = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-2:0], acc};
    end
  end

  // stage 1: edge and offset vectors
  logic [2:0][C-1:0] p_in, a_in, b_in, c_in;
  geo_t              geo_d, s1_geo_q;
  logic [2:0][C:0]   s1_ap_q, s1_bp_q, s1_cp_q;

  assign p_in = {pz_i, py_i, px_i};
  assign a_in = {az_i, ay_i, ax_i};
  assign b_in = {bz_i, by_coord_i, bx_i};
  assign c_in = {cz_i, cy_i, cx_i};

  always_comb begin
    geo_d.a = a_in;
    geo_d.b = b_in;
    geo_d.c = c_in;
    for (int k = 0; k < 3; k++) begin
      geo_d.ab[k] = sx1(b_in[k]) - sx1(a_in[k]);
      geo_d.ac[k] = sx1(c_in[k]) - sx1(a_in[k]);
      geo_d.bc[k] = sx1(c_in[k]) - sx1(b_in[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_geo_q <= geo_d;
    for (int k = 0; k < 3; k++) begin
      s1_ap_q[k] <= sx1(p_in[k]) - sx1(a_in[k]);
      s1_bp_q[k] <= sx1(p_in[k]) - sx1(b_in[k]);
      s1_cp_q[k] <= sx1(p_in[k]) - sx1(c_in[k]);
    end
  end

  // stage 2: dot product terms
  logic [5:0][2:0][C:0]     mu, mv;
  logic signed [PW2-1:0]    s2_pr_q [6][3];
  geo_t                     s2_geo_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mu[0][k] = s1_geo_q.ab[k]; mv[0][k] = s1_ap_q[k];
      mu[1][k] = s1_geo_q.ac[k]; mv[1][k] = s1_ap_q[k];
      mu[2][k] = s1_geo_q.ab[k]; mv[2][k] = s1_bp_q[k];
      mu[3][k] = s1_geo_q.ac[k]; mv[3][k] = s1_bp_q[k];
      mu[4][k] = s1_geo_q.ab[k]; mv[4][k] = s1_cp_q[k];
      mu[5][k] = s1_geo_q.ac[k]; mv[5][k] = s1_cp_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    s2_geo_q <= s1_geo_q;
    for (int i = 0; i < 6; i++) begin
      for (int k = 0; k < 3; k++) begin
        s2_pr_q[i][k] <= PW2'($signed(mu[i][k])) * PW2'($signed(mv[i][k]));
      end
    end
  end

  // stage 3: d1..d6
  logic signed [DW-1:0] s3_d_q [6];
  geo_t                 s3_geo_q;

  always_ff @(posedge clk_i) begin
    s3_geo_q <= s2_geo_q;
    for (int i = 0; i < 6; i++) begin
      s3_d_q[i] <= DW'(s2_pr_q[i][0]) + DW'(s2_pr_q[i][1]) + DW'(s2_pr_q[i][2]);
    end
  end

  // stage 4: split products for va, vb, vc
  logic signed [DW-1:0] mx [3][2];
  logic signed [DW-1:0] my [3][2];
  logic signed [LW-1:0] s4_pl_q [3][2];
  logic signed [HW-1:0] s4_ph_q [3][2];
  logic signed [DW-1:0] s4_d_q [6];
  geo_t                 s4_geo_q;

  always_comb begin
    mx[0][0] = s3_d_q[2]; my[0][0] = s3_d_q[5];
    mx[0][1] = s3_d_q[4]; my[0][1] = s3_d_q[3];
    mx[1][0] = s3_d_q[4]; my[1][0] = s3_d_q[1];
    mx[1][1] = s3_d_q[0]; my[1][1] = s3_d_q[5];
    mx[2][0] = s3_d_q[0]; my[2][0] = s3_d_q[3];
    mx[2][1] = s3_d_q[2]; my[2][1] = s3_d_q[1];
  end

  always_ff @(posedge clk_i) begin
    s4_geo_q <= s3_geo_q;
    s4_d_q   <= s3_d_q;
    for (int j = 0; j < 3; j++) begin
      for (int t = 0; t < 2; t++) begin
        s4_pl_q[j][t] <= LW'(mx[j][t]) * LW'($signed({1'b0, my[j][t][H-1:0]}));
        s4_ph_q[j][t] <= HW'(mx[j][t]) * HW'($signed(my[j][t][DW-1:H]));
      end
    end
  end

  // stage 5: barycentric products
  logic signed [VW-1:0] s5_v_q [3];
  logic signed [DW-1:0] s5_d_q [6];
  geo_t                 s5_geo_q;

  always_ff @(posedge clk_i) begin
    s5_geo_q <= s4_geo_q;
    s5_d_q   <= s4_d_q;
    for (int j = 0; j < 3; j++) begin
      s5_v_q[j] <= ((VW'(s4_ph_q[j][0]) <<< H) + VW'(s4_pl_q[j][0]))
                 - ((VW'(s4_ph_q[j][1]) <<< H) + VW'(s4_pl_q[j][1]));
    end
  end

  // stage 6: region classification
  logic signed [DW-1:0] d1, d2, d3, d4, d5, d6;
  logic signed [VW-1:0] va, vb, vc;
  pre_t                 pre_d, s6_pre_q;
  logic [2:0][C:0]      m1_d, m2_d, s6_m1_q, s6_m2_q;
  logic signed [VW-1:0] f1_d, f2_d, s6_f1_q, s6_f2_q;

  assign d1 = s5_d_q[0];
  assign d2 = s5_d_q[1];
  assign d3 = s5_d_q[2];
  assign d4 = s5_d_q[3];
  assign d5 = s5_d_q[4];
  assign d6 = s5_d_q[5];
  assign va = s5_v_q[0];
  assign vb = s5_v_q[1];
  assign vc = s5_v_q[2];

  always_comb begin
    pre_d.region = cpt_pkg::RegFace;
    pre_d.vtx    = 1'b0;
    pre_d.deg    = 1'b0;
    pre_d.fq     = s5_geo_q.a;
    pre_d.base   = s5_geo_q.a;
    pre_d.den    = '0;
    m1_d         = s5_geo_q.ab;
    m2_d         = '0;
    f1_d         = '0;
    f2_d         = '0;
    if (d1 <= 0 && d2 <= 0) begin
      pre_d.region = cpt_pkg::RegVtxA;
      pre_d.vtx    = 1'b1;
    end else if (d3 >= 0 && d4 <= d3) begin
      pre_d.region = cpt_pkg::RegVtxB;
      pre_d.vtx    = 1'b1;
      pre_d.fq     = s5_geo_q.b;
    end else if (le0(vc) && d1 >= 0 && d3 <= 0) begin
      pre_d.region = cpt_pkg::RegEdgeAb;
      f1_d         = VW'(d1);
      pre_d.den    = FDW'(d1) - FDW'(d3);
    end else if (d6 >= 0 && d5 <= d6) begin
      pre_d.region = cpt_pkg::RegVtxC;
      pre_d.vtx    = 1'b1;
      pre_d.fq     = s5_geo_q.c;
    end else if (le0(vb) && d2 >= 0 && d6 <= 0) begin
      pre_d.region = cpt_pkg::RegEdgeAc;
      m1_d         = s5_geo_q.ac;
      f1_d         = VW'(d2);
      pre_d.den    = FDW'(d2) - FDW'(d6);
    end else if (le0(va) && d4 >= d3 && d5 >= d6) begin
      pre_d.region = cpt_pkg::RegEdgeBc;
      pre_d.base   = s5_geo_q.b;
      m1_d         = s5_geo_q.bc;
      f1_d         = VW'(d4) - VW'(d3);
      pre_d.den    = (FDW'(d4) - FDW'(d3)) + (FDW'(d5) - FDW'(d6));
    end else begin
      m2_d      = s5_geo_q.ac;
      f1_d      = vb;
      f2_d      = vc;
      pre_d.den = FDW'(va) + FDW'(vb) + FDW'(vc);
    end
  end

  always_ff @(posedge clk_i) begin
    s6_pre_q <= pre_d;
    s6_m1_q  <= m1_d;
    s6_m2_q  <= m2_d;
    s6_f1_q  <= f1_d;
    s6_f2_q  <= f2_d;
  end

  // stage 7: numerator partial products
  logic signed [FPW-1:0] fpad [2];
  logic [K:0]            ch [2][NCH];
  logic [2:0][C:0]       mm [2];
  logic signed [PW-1:0]  s7_pp_q [3][2][NCH];
  pre_t                  pre7_d, s7_pre_q;

  always_comb begin
    pre7_d     = s6_pre_q;
    pre7_d.deg = ~s6_pre_q.vtx & (s6_pre_q.den == '0);
    fpad[0] = FPW'(s6_f1_q);
    fpad[1] = FPW'(s6_f2_q);
    mm[0]   = s6_m1_q;
    mm[1]   = s6_m2_q;
    for (int t = 0; t < 2; t++) begin
      for (int i = 0; i < NCH - 1; i++) begin
        ch[t][i] = {1'b0, fpad[t][i*K +: K]};
      end
      ch[t][NCH-1] = {fpad[t][FPW-1], fpad[t][FPW-1 -: K]};
    end
  end

  always_ff @(posedge clk_i) begin
    s7_pre_q <= pre7_d;
    for (int k = 0; k < 3; k++) begin
      for (int t = 0; t < 2; t++) begin
        for (int i = 0; i < NCH; i++) begin
          s7_pp_q[k][t][i] <= PW'($signed(mm[t][k])) * PW'($signed(ch[t][i]));
        end
      end
    end
  end

  // stage 8: numerators
  logic signed [NW-1:0] num_d [3];
  logic signed [NW-1:0] s8_num_q [3];
  pre_t                 s8_pre_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_d[k] = '0;
      for (int t = 0; t < 2; t++) begin
        for (int i = 0; i < NCH; i++) begin
          num_d[k] = num_d[k] + (NW'(s7_pp_q[k][t][i]) <<< (i * K));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s8_pre_q <= s7_pre_q;
    s8_num_q <= num_d;
  end

  // stage 9: round to nearest, split sign and magnitude
  logic signed [NW+1:0] n2 [3];
  logic [NW+1:0]        magn [3];
  side_t                side_d;

  logic [EW-1:0] dv_rem_q  [QB+1][3];
  logic [QB-1:0] dv_quo_q  [QB+1][3];
  side_t         dv_side_q [QB+1];

  always_comb begin
    side_d.region = s8_pre_q.deg ? cpt_pkg::RegVtxA : s8_pre_q.region;
    side_d.deg    = s8_pre_q.deg;
    side_d.fb     = s8_pre_q.vtx | s8_pre_q.deg;
    side_d.fq     = s8_pre_q.fq;
    side_d.base   = s8_pre_q.base;
    side_d.d2     = {s8_pre_q.den, 1'b0};
    for (int k = 0; k < 3; k++) begin
      n2[k]         = ((NW + 2)'(s8_num_q[k]) <<< 1) + (NW + 2)'(s8_pre_q.den);
      side_d.neg[k] = n2[k][NW+1];
      magn[k]       = side_d.neg[k] ? (NW + 2)'(-n2[k]) : n2[k];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_side_q[0] <= side_d;
    for (int k = 0; k < 3; k++) begin
      dv_rem_q[0][k] <= EW'(magn[k]);
      dv_quo_q[0][k] <= '0;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar s = 0; s < QB; s++) begin : g_div
    localparam int J = QB - 1 - s;
    logic [EW-1:0] sd;

    assign sd = EW'(dv_side_q[s].d2) << J;

    always_ff @(posedge clk_i) begin
      dv_side_q[s+1] <= dv_side_q[s];
      for (int k = 0; k < 3; k++) begin
        if (dv_rem_q[s][k] >= sd) begin
          dv_rem_q[s+1][k] <= dv_rem_q[s][k] - sd;
          dv_quo_q[s+1][k] <= dv_quo_q[s][k] | (QB'(1) << J);
        end else begin
          dv_rem_q[s+1][k] <= dv_rem_q[s][k];
          dv_quo_q[s+1][k] <= dv_quo_q[s][k];
        end
      end
    end
  end

  // output stage
  logic [QB:0]       off [3];
  logic [2:0][C-1:0] q_d, q_q;
  logic [2:0]        region_q;
  logic              deg_q;
  side_t             fin;

  assign fin = dv_side_q[QB];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (fin.neg[k]) begin
        off[k] = -(QB + 1)'(dv_quo_q[QB][k])
               - (QB + 1)'(dv_rem_q[QB][k] != '0);
      end else begin
        off[k] = (QB + 1)'(dv_quo_q[QB][k]);
      end
      q_d[k] = fin.fb ? fin.fq[k] : fin.base[k] + off[k][C-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    q_q      <= q_d;
    region_q <= fin.region;
    deg_q    <= fin.deg;
  end

  assign done_o       = vld_q[NS-1];
  assign qx_o         = q_q[0];
  assign qy_o         = q_q[1];
  assign qz_o         = q_q[2];
  assign region_o     = region_q;
  assign degenerate_o = deg_q;

endmodule
`default_nettype wire

// ----- rtl/cpt_checker.sv -----
// port level checks for the closest point on triangle block, with bind
`timescale 1ns / 1ps
`default_nettype none
module cpt_checker #(
  parameter int unsigned COORD_BITS = cpt_pkg::CoordBitsDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic [2:0] region_o,
  input logic       degenerate_o
);

  localparam int Lat = COORD_BITS + 14;
  localparam int CW  = $clog2(Lat + 1);

  logic [CW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cnt_q != CW'(Lat)) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CW'(Lat)) |-> (done_o == $past(start_i && !busy_o, Lat)))
    else $error("result strobe does not match request latency");

  a_no_early_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !done_o)
    else $error("result right after reset");

  a_degen_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (region_o == cpt_pkg::RegVtxA))
    else $error("degenerate result not in vertex a region");

endmodule

bind closest_point_on_triangle cpt_checker #(.COORD_BITS(COORD_BITS)) u_cpt_checker (.*);
`default_nettype wire
